// ===== rtl/ftrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Five-tuple rule classifier package
// Shared constants, command codes and types of the rule classifier.
// ============================================================================
package ftrc_pkg;

    localparam int MAX_RULES  = 64;
    localparam int IDX_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W      = $clog2(MAX_RULES + 1);
    localparam int HIT_W      = 6;
    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [1:0] CMD_LOAD       = 2'd0;
    localparam logic [1:0] CMD_CLASSIFY   = 2'd1;
    localparam logic [1:0] CMD_CLEAR      = 2'd2;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_DROP   = 2'd1;

    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;

    typedef struct packed {
        logic        logs;
        logic [1:0]  verdict;
        logic        dir;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] dst;
        logic [31:0] src;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    typedef struct packed {
        logic [5:0]       pad;
        logic             table_full;
        logic             log_request;
        logic [HIT_W-1:0] hit_index;
        logic             hit;
        logic             drop;
    } t_result;

    typedef struct packed {
        logic accept;
        logic start;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic rules_empty;
        logic search_busy;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/five_tuple_rule_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Five-tuple rule classifier
// First-match firewall rule table with load, classify and clear commands.
//
// Each slave-side transaction carries a command in tuser and a rule or a
// packet five-tuple in tdata. Load appends a rule, classify searches the
// stored rules from the newest to the oldest, clear empties the table.
// Every transaction gives exactly one master-side result transaction.
// The configuration channel writes the default verdict and is always ready.
// Load, clear, unknown commands and a classify on an empty table pass from
// acceptance straight to the finish state. A classify over stored rules
// first searches them through the single read port of the rule memory, one
// rule per cycle; a deciding hit ends the search early. The finish state
// loads the output register once it is free. The next transaction can be
// accepted in the cycle after the output register is loaded, even while that
// result still waits for the receiver. While the receiver stalls, a finished
// result holds the block until the output register frees.
// Reset empties the table and clears the default verdict to pass. No memory
// clearing pass is needed; only slots below the rule count are read.
// ============================================================================
module five_tuple_rule_classifier (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // src_addr, dst_addr, src_port_num, dst_port_num, ip_proto, flow_dir,
    // rule_verdict, rule_logs, zero fill.
    input  wire logic [ftrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd.
    input  wire logic [ftrc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // drop, hit, hit_index, log_request, table_full, zero fill.
    output logic [ftrc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic                               i_cfg_data
);
    import ftrc_pkg::*;

    t_ctrl_cmd  ctrl;
    t_dp_status status;
    t_rule      in_rule;

    assign in_rule     = t_rule'(s_axis_tdata[RULE_W-1:0]);
    assign o_cfg_ready = 1'b1;

    ftrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    ftrc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (in_rule),
        .i_in_cmd    (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/ftrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Rule classifier controller
// Sequences each transaction through acceptance, a classify search and result.
// ============================================================================
module ftrc_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic [1:0]             i_in_cmd,
    output logic                        o_in_ready,
    input  wire ftrc_pkg::t_dp_status   i_status,
    output ftrc_pkg::t_ctrl_cmd         o_ctrl
);
    import ftrc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign o_ctrl.accept   = accept;
    assign o_ctrl.start    = accept && (i_in_cmd == CMD_CLASSIFY) && !i_status.rules_empty;
    assign o_ctrl.out_load = (r_state == ST_FINISH) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = o_ctrl.start ? ST_SEARCH : ST_FINISH;
                end
            end
            ST_SEARCH: begin
                if (!i_status.search_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ftrc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Rule classifier datapath
// Rule memory, rule count, newest-first search pipeline and result register.
// ============================================================================
module ftrc_dpath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ftrc_pkg::t_rule                    i_in_data,
    input  wire logic [1:0]                         i_in_cmd,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_data,
    input  wire ftrc_pkg::t_ctrl_cmd                i_ctrl,
    output ftrc_pkg::t_dp_status                    o_status,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic [ftrc_pkg::OUT_DATA_W-1:0]         o_out_data
);
    import ftrc_pkg::*;

    t_rule             r_mem [MAX_RULES];
    t_rule             r_rd_data;
    t_rule             r_pkt;
    logic [1:0]        r_cmd;
    logic              r_full;
    logic [CNT_W-1:0]  r_rule_cnt;
    logic              r_default_drop;
    logic              r_issue;
    logic              r_pend;
    logic [IDX_W-1:0]  r_next_slot;
    logic [IDX_W-1:0]  r_cmp_slot;
    logic              r_decided;
    logic              r_log;
    logic [IDX_W-1:0]  r_hit_slot;
    logic              r_hit_drop;
    logic              r_out_valid;
    t_result           r_out_data;

    logic              full_now;
    logic              wr_en;
    logic              is_l4;
    logic              match;
    logic              decides;
    t_rule             pkt_in;
    t_result           res;

    assign full_now = (r_rule_cnt == CNT_W'(MAX_RULES));
    assign wr_en    = i_ctrl.accept && (i_in_cmd == CMD_LOAD) && !full_now;
    assign is_l4    = (i_in_data.proto == PROTO_TCP) || (i_in_data.proto == PROTO_UDP);

    always_comb begin
        pkt_in = i_in_data;
        if (!is_l4) begin
            pkt_in.sport = '0;
            pkt_in.dport = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_rule_cnt[IDX_W-1:0]] <= i_in_data;
        end
        if (r_issue) begin
            r_rd_data <= r_mem[r_next_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_cnt <= '0;
        end else if (wr_en) begin
            r_rule_cnt <= r_rule_cnt + CNT_W'(1);
        end else if (i_ctrl.accept && (i_in_cmd == CMD_CLEAR)) begin
            r_rule_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_drop <= 1'b0;
        end else if (i_cfg_valid) begin
            r_default_drop <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= i_in_cmd;
            r_pkt  <= pkt_in;
            r_full <= (i_in_cmd == CMD_LOAD) && full_now;
        end
    end

    assign match = ((r_rd_data.src   == '0) || (r_rd_data.src   == r_pkt.src))   &&
                   ((r_rd_data.dst   == '0) || (r_rd_data.dst   == r_pkt.dst))   &&
                   ((r_rd_data.sport == '0) || (r_rd_data.sport == r_pkt.sport)) &&
                   ((r_rd_data.dport == '0) || (r_rd_data.dport == r_pkt.dport)) &&
                   ((r_rd_data.proto == '0) || (r_rd_data.proto == r_pkt.proto)) &&
                   (r_rd_data.dir == r_pkt.dir);

    assign decides = r_pend && match &&
                     ((r_rd_data.verdict == VERDICT_ACCEPT) ||
                      (r_rd_data.verdict == VERDICT_DROP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_ctrl.start) begin
            r_issue     <= 1'b1;
            r_pend      <= 1'b0;
            r_next_slot <= IDX_W'(r_rule_cnt - CNT_W'(1));
        end else begin
            r_pend <= r_issue;
            if (r_issue) begin
                r_cmp_slot <= r_next_slot;
                if (r_next_slot == '0) begin
                    r_issue <= 1'b0;
                end else begin
                    r_next_slot <= r_next_slot - IDX_W'(1);
                end
            end
            if (decides) begin
                r_issue <= 1'b0;
                r_pend  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decided <= 1'b0;
            r_log     <= 1'b0;
        end else if (i_ctrl.accept) begin
            r_decided <= 1'b0;
            r_log     <= 1'b0;
        end else if (r_pend && match) begin
            if (r_rd_data.logs) begin
                r_log <= 1'b1;
            end
            if (decides) begin
                r_decided  <= 1'b1;
                r_hit_slot <= r_cmp_slot;
                r_hit_drop <= (r_rd_data.verdict == VERDICT_DROP);
            end
        end
    end

    always_comb begin
        res = '0;
        case (r_cmd)
            CMD_CLASSIFY: begin
                res.drop        = r_decided ? r_hit_drop : r_default_drop;
                res.hit         = r_decided;
                res.hit_index   = r_decided ? HIT_W'(r_hit_slot) : '0;
                res.log_request = r_log;
            end
            CMD_LOAD: begin
                res.table_full = r_full;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_data <= res;
        end
    end

    assign o_status.rules_empty = (r_rule_cnt == '0);
    assign o_status.search_busy = r_issue || r_pend;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== tb/tb_five_tuple_rule_classifier.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Five-tuple rule classifier testbench
// Loads rule sets, classifies packets built to hit stored rules, fills and
// overflows the table, clears it and changes the default verdict. Each result
// transaction is checked against a first-match rule table kept in a class.
// ============================================================================
module tb_five_tuple_rule_classifier;

    import ftrc_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [1:0] VERDICT_OTHER = 2'd2;
    localparam logic [1:0] VERDICT_SPARE = 2'd3;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam int         ITEM_TARGET   = 450;

    class rule_table_scoreboard;
        t_rule       rule_tab[MAX_RULES];
        int unsigned rule_cnt;
        bit          default_drop;
        t_result     outcome_q[$];
        int          errors, n_checked;
        int          n_load, n_full, n_classify, n_hit, n_log, n_clear;

        function new();
            rule_cnt = 0;
            default_drop = 1'b0;
            errors = 0;
            n_checked = 0;
            n_load = 0;
            n_full = 0;
            n_classify = 0;
            n_hit = 0;
            n_log = 0;
            n_clear = 0;
        endfunction

        function t_result predict_outcome(logic [1:0] cmd, t_rule p);
            t_result res;
            t_rule   r;
            logic [15:0] sp, dp;
            int      s;
            bit      decided;
            res = '0;
            decided = 1'b0;
            case (cmd)
                CMD_LOAD: begin
                    n_load++;
                    if (rule_cnt >= MAX_RULES) begin
                        res.table_full = 1'b1;
                        n_full++;
                    end else begin
                        rule_tab[rule_cnt] = p;
                        rule_cnt++;
                    end
                end
                CMD_CLASSIFY: begin
                    n_classify++;
                    sp = p.sport;
                    dp = p.dport;
                    // Ports only count for TCP and UDP packets.
                    if (p.proto != PROTO_TCP && p.proto != PROTO_UDP) begin
                        sp = '0;
                        dp = '0;
                    end
                    for (s = int'(rule_cnt) - 1; s >= 0 && !decided; s--) begin
                        r = rule_tab[s];
                        if ((r.src == '0 || r.src == p.src) &&
                            (r.dst == '0 || r.dst == p.dst) &&
                            (r.sport == '0 || r.sport == sp) &&
                            (r.dport == '0 || r.dport == dp) &&
                            (r.proto == '0 || r.proto == p.proto) &&
                            r.dir == p.dir) begin
                            if (r.logs) res.log_request = 1'b1;
                            if (r.verdict == VERDICT_ACCEPT || r.verdict == VERDICT_DROP) begin
                                decided = 1'b1;
                                res.hit = 1'b1;
                                res.hit_index = 6'(s);
                                res.drop = (r.verdict == VERDICT_DROP);
                            end
                        end
                    end
                    if (!decided) res.drop = default_drop;
                    if (decided) n_hit++;
                    if (res.log_request) n_log++;
                end
                CMD_CLEAR: begin
                    n_clear++;
                    rule_cnt = 0;
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_input(logic [1:0] cmd, t_rule p);
            outcome_q.push_back(predict_outcome(cmd, p));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            t_result got, want;
            got = t_result'(word);
            n_checked++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result transaction: drop=%0b hit=%0b idx=%0d log=%0b full=%0b",
                             got.drop, got.hit, got.hit_index, got.log_request, got.table_full);
                return;
            end
            want = outcome_q.pop_front();
            if (got.drop !== want.drop || got.hit !== want.hit ||
                got.hit_index !== want.hit_index || got.log_request !== want.log_request ||
                got.table_full !== want.table_full) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch on result %0d: expected drop=%0b hit=%0b idx=%0d log=%0b full=%0b, got drop=%0b hit=%0b idx=%0d log=%0b full=%0b",
                             n_checked, want.drop, want.hit, want.hit_index, want.log_request,
                             want.table_full, got.drop, got.hit, got.hit_index,
                             got.log_request, got.table_full);
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_data;

    rule_table_scoreboard sb;
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_cycles;
    int n_sent;
    int phase;
    int n_rules;
    int n_pkts;

    five_tuple_rule_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_rule mk_rule(logic [31:0] src, logic [31:0] dst, logic [15:0] sport,
                                      logic [15:0] dport, logic [7:0] proto, logic dir,
                                      logic [1:0] verdict, logic logs);
        t_rule r;
        r.src = src;
        r.dst = dst;
        r.sport = sport;
        r.dport = dport;
        r.proto = proto;
        r.dir = dir;
        r.verdict = verdict;
        r.logs = logs;
        return r;
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(3))
            0: return PROTO_TCP;
            1: return PROTO_UDP;
            2: return PROTO_ICMP;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_rule rand_packet();
        t_rule p;
        p.src = ($urandom_range(15) == 0) ? 32'd0 : 32'($urandom());
        p.dst = ($urandom_range(15) == 0) ? 32'd0 : 32'($urandom());
        p.sport = 16'($urandom_range(65535));
        p.dport = 16'($urandom_range(65535));
        p.proto = pick_proto();
        p.dir = 1'($urandom_range(1));
        p.verdict = 2'($urandom_range(3));
        p.logs = 1'($urandom_range(1));
        return p;
    endfunction

    function automatic t_rule rand_rule();
        t_rule r;
        int v;
        r = rand_packet();
        if ($urandom_range(99) < 40) r.src = '0;
        if ($urandom_range(99) < 40) r.dst = '0;
        if ($urandom_range(99) < 50) r.sport = '0;
        if ($urandom_range(99) < 50) r.dport = '0;
        if ($urandom_range(4) == 0) r.proto = '0;
        v = int'($urandom_range(9));
        if (v < 4) r.verdict = VERDICT_ACCEPT;
        else if (v < 8) r.verdict = VERDICT_DROP;
        else if (v == 8) r.verdict = VERDICT_OTHER;
        else r.verdict = VERDICT_SPARE;
        return r;
    endfunction

    // The packet copies the rule's non-zero addresses, ports and protocol and mostly its dir, so usually matches.
    function automatic t_rule packet_like(t_rule r);
        t_rule p;
        p = rand_packet();
        if (r.src != '0) p.src = r.src;
        if (r.dst != '0) p.dst = r.dst;
        if (r.sport != '0) p.sport = r.sport;
        if (r.dport != '0) p.dport = r.dport;
        if (r.proto != '0) p.proto = r.proto;
        p.dir = ($urandom_range(7) == 0) ? ~r.dir : r.dir;
        return p;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input t_rule item);
        while (tx_idle_en && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_DATA_W - RULE_W){1'b0}}, item};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, item);
        if (cmd != CMD_UNUSED) n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.default_drop = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_idle_en && $urandom_range(99) < 37) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("FAIL five_tuple_rule_classifier");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_cycles = 0;
        n_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, unknown command, wildcards, exact
        // all-ones rule, non-TCP/UDP port handling and skipped verdicts.
        cfg_write(1'b1);
        send_item(CMD_CLASSIFY, mk_rule('1, '1, '1, '1, PROTO_TCP, 1'b1, VERDICT_SPARE, 1'b1));
        send_item(CMD_CLEAR, mk_rule('0, '0, '0, '0, '0, 1'b0, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_UNUSED, mk_rule('1, '1, '1, '1, '1, 1'b1, VERDICT_SPARE, 1'b1));
        send_item(CMD_LOAD, mk_rule('0, '0, '0, '0, '0, 1'b1, VERDICT_ACCEPT, 1'b1));
        send_item(CMD_LOAD, mk_rule('0, '0, '0, '0, '0, 1'b0, VERDICT_OTHER, 1'b1));
        send_item(CMD_LOAD, mk_rule('1, '1, '1, '1, PROTO_TCP, 1'b1, VERDICT_DROP, 1'b0));
        send_item(CMD_LOAD, mk_rule(32'h0a00_0001, '0, '0, 16'd53, PROTO_UDP, 1'b0,
                                    VERDICT_ACCEPT, 1'b0));
        send_item(CMD_LOAD, mk_rule('0, '0, 16'd80, '0, PROTO_ICMP, 1'b0, VERDICT_DROP, 1'b0));
        send_item(CMD_LOAD, mk_rule('0, '0, '0, '0, PROTO_ICMP, 1'b0, VERDICT_SPARE, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule('1, '1, '1, '1, PROTO_TCP, 1'b1, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule('1, '1, 16'hfffe, '1, PROTO_TCP, 1'b1,
                                        VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule(32'h0a00_0001, 32'hc0a8_0101, 16'd4000, 16'd53,
                                        PROTO_UDP, 1'b0, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule(32'h0a00_0002, 32'h0a00_0003, 16'd80, 16'd80,
                                        PROTO_ICMP, 1'b0, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule('0, '0, '0, '0, '0, 1'b0, VERDICT_ACCEPT, 1'b0));
        wait_drain();
        cfg_write(1'b0);
        send_item(CMD_CLASSIFY, mk_rule('0, '0, '0, '0, '0, 1'b0, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLASSIFY, mk_rule(32'h0a00_0002, 32'h0a00_0003, 16'd80, 16'd80,
                                        PROTO_ICMP, 1'b0, VERDICT_ACCEPT, 1'b0));
        send_item(CMD_CLEAR, mk_rule('1, '1, '1, '1, '1, 1'b1, VERDICT_SPARE, 1'b1));
        send_item(CMD_CLASSIFY, mk_rule('1, '1, '1, '1, PROTO_TCP, 1'b1, VERDICT_ACCEPT, 1'b0));

        // Random part: each phase loads a rule set, then classifies packets
        // mostly derived from stored rules. Two phases overflow the table.
        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            wait_drain();
            cfg_write(1'($urandom_range(1)));
            tx_idle_en = (phase != 1);
            rx_idle_en = (phase != 1);
            if (phase == 2 || phase == 6 || sb.rule_cnt >= 40 || $urandom_range(3) == 0)
                send_item(CMD_CLEAR, rand_packet());
            n_rules = (phase == 2 || phase == 6) ? MAX_RULES + 3 : int'($urandom_range(1, 10));
            repeat (n_rules) begin
                if ($urandom_range(24) == 0) send_item(CMD_UNUSED, rand_packet());
                send_item(CMD_LOAD, rand_rule());
            end
            // The receiver stalls long enough for the block to back up its input.
            if (phase == 3) rx_hold_cycles = 400;
            n_pkts = int'($urandom_range(6, 24));
            repeat (n_pkts) begin
                if ($urandom_range(14) == 0)
                    send_item(CMD_LOAD, rand_rule());
                else if (sb.rule_cnt != 0 && $urandom_range(9) < 8)
                    send_item(CMD_CLASSIFY,
                              packet_like(sb.rule_tab[$urandom_range(sb.rule_cnt - 1)]));
                else
                    send_item(CMD_CLASSIFY, rand_packet());
            end
            phase++;
        end

        wait_drain();
        repeat (80) @(negedge i_clk);
        if (sb.pending() != 0) sb.errors++;
        $display("Sent %0d loads (%0d refused on a full table), %0d classifies and %0d clears.",
                 sb.n_load, sb.n_full, sb.n_classify, sb.n_clear);
        $display("%0d packets decided by a rule, %0d with a log request, %0d results checked, %0d errors.",
                 sb.n_hit, sb.n_log, sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS five_tuple_rule_classifier");
        end else begin
            $display("FAIL five_tuple_rule_classifier");
        end
        $finish;
    end

endmodule
